### design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

### design/wocs_pkg.sv
// shared types, constants and sine table builder for the tone generator
`timescale 1ns / 1ps

package wocs_pkg;

    // sizing
    localparam int SINE_TABLE_BITS = 10;
    localparam int COUNT_BITS      = 20;
    localparam int QSTEPS          = 1 << SINE_TABLE_BITS;
    localparam int ADDR_W          = SINE_TABLE_BITS + 1;
    localparam int TONE_LEN_W      = 20;
    localparam int CMP_W           = ((COUNT_BITS > TONE_LEN_W) ? COUNT_BITS : TONE_LEN_W) + 1;
    localparam int CFG_DATA_W      = 32;
    localparam int CFG_INDEX_W     = 2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_WAVEFORM_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TONE_LENGTH   = 2'd2;

    // waveform codes
    localparam logic [1:0] MODE_SINE   = 2'd0;
    localparam logic [1:0] MODE_SAW    = 2'd1;
    localparam logic [1:0] MODE_SQUARE = 2'd2;

    // register reset values
    localparam logic [31:0]           PHASE_STEP_RESET  = 32'd25480000;
    localparam logic [TONE_LEN_W-1:0] TONE_LENGTH_RESET = 20'd13230;

    // clip constants: 0.6 in q15 and output scale
    localparam logic [14:0] CLIP_K     = 15'd19661;
    localparam logic [14:0] CLIP_SCALE = 15'd30000;
    localparam logic [15:0] ONE_Q15    = 16'h8000;

    // pi/2 in q2.30 and taylor divisors (2n)(2n+1)
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic [9:0]  TAYLOR_DIV [1:10] = '{10'd6, 10'd20, 10'd42, 10'd72, 10'd110,
                                                  10'd156, 10'd210, 10'd272, 10'd342, 10'd420};

    typedef logic [15:0] sine_table_t [0:QSTEPS];

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_CLIP,
        ST_HOLD
    } wocs_state_t;

    typedef enum logic [2:0] {
        CL_IDLE,
        CL_MULN,
        CL_MULD,
        CL_DIV,
        CL_DONE
    } wocs_clip_state_t;

    typedef struct packed {
        logic        start;
        logic [15:0] magnitude;
    } wocs_clip_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] quotient;
    } wocs_clip_rsp_t;

    // one quarter-wave entry in q1.15 from an integer taylor series
    function automatic logic [15:0] sine_entry(int unsigned k);
        logic [63:0]        ang;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] acc;
        logic signed [63:0] r;
        ang  = (PI_HALF_Q30 * 64'(k) + 64'(QSTEPS / 2)) >> SINE_TABLE_BITS;
        x2   = (ang * ang) >> 30;
        term = ang;
        acc  = $signed(ang);
        for (int n = 1; n <= 10; n++) begin
            term = ((term * x2) >> 30) / 64'(TAYLOR_DIV[n]);
            if (n % 2 == 1)
                acc = acc - $signed(term);
            else
                acc = acc + $signed(term);
        end
        if (acc < 0)
            acc = 0;
        r = (acc + 64'sd16384) >>> 15;
        if (r > 64'sd32768)
            r = 64'sd32768;
        return r[15:0];
    endfunction

    function automatic sine_table_t build_sine_table();
        sine_table_t t;
        for (int k = 0; k <= QSTEPS; k++)
            t[k] = sine_entry(k);
        return t;
    endfunction

endpackage

### design/wocs_channels.sv
// valid/ready channel interfaces for tick requests and pcm results
`timescale 1ns / 1ps

interface wocs_tick_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface wocs_sample_if;
    logic        valid;
    logic        ready;
    logic [15:0] pcm_sample;
    logic        tone_end;

    modport source (output valid, output pcm_sample, output tone_end, input ready);
    modport sink   (input valid, input pcm_sample, input tone_end, output ready);
endinterface

### design/wocs_sine_rom.sv
// quarter-wave sine table with registered read
`timescale 1ns / 1ps

module wocs_sine_rom (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [wocs_pkg::ADDR_W-1:0] addr,
    output logic [15:0]                data
);

    localparam wocs_pkg::sine_table_t SINE_LUT = wocs_pkg::build_sine_table();

    logic [15:0] data_reg;

    // registered lookup
    always_ff @(posedge clk)
    begin
        if (rd_en)
            data_reg <= SINE_LUT[addr];
    end

    assign data = data_reg;

endmodule

### design/wocs_clip_unit.sv
// soft clip and scale: two products then a 16-step restoring divider
`timescale 1ns / 1ps

module wocs_clip_unit (
    input  logic                     clk,
    input  logic                     rst_n,
    input  wocs_pkg::wocs_clip_req_t req,
    output wocs_pkg::wocs_clip_rsp_t rsp
);

    wocs_pkg::wocs_clip_state_t state_reg, state_next;

    logic [15:0] a_reg;
    logic [29:0] prod_reg;
    logic [30:0] den_reg;
    logic [30:0] rem_reg;
    logic [15:0] lo_reg;
    logic [3:0]  cnt_reg;

    logic [30:0] num_full;
    logic [30:0] kden_full;
    logic [31:0] trial;
    logic [31:0] diff;
    logic        ge;

    // products and one divider step
    assign num_full  = a_reg * wocs_pkg::CLIP_SCALE;
    assign kden_full = a_reg * wocs_pkg::CLIP_K;
    assign trial     = {rem_reg, lo_reg[15]};
    assign ge        = trial >= {1'b0, den_reg};
    assign diff      = trial - {1'b0, den_reg};

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= wocs_pkg::CL_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wocs_pkg::CL_IDLE:
            begin
                if (req.start)
                    state_next = wocs_pkg::CL_MULN;
            end
            wocs_pkg::CL_MULN: state_next = wocs_pkg::CL_MULD;
            wocs_pkg::CL_MULD: state_next = wocs_pkg::CL_DIV;
            wocs_pkg::CL_DIV:
            begin
                if (cnt_reg == 4'd0)
                    state_next = wocs_pkg::CL_DONE;
            end
            wocs_pkg::CL_DONE: state_next = wocs_pkg::CL_IDLE;
            default:           state_next = wocs_pkg::CL_IDLE;
        endcase
    end

    // datapath: numerator is prod * 2^15, its top bits seed the remainder
    always_ff @(posedge clk)
    begin
        case (state_reg)
            wocs_pkg::CL_IDLE:
            begin
                if (req.start)
                    a_reg <= req.magnitude;
            end
            wocs_pkg::CL_MULN:
            begin
                prod_reg <= num_full[29:0];
            end
            wocs_pkg::CL_MULD:
            begin
                // denominator 2^30 + k * a
                den_reg <= 31'h4000_0000 + kden_full;
                rem_reg <= {2'b00, prod_reg[29:1]};
                lo_reg  <= {prod_reg[0], 15'd0};
                cnt_reg <= 4'd15;
            end
            wocs_pkg::CL_DIV:
            begin
                rem_reg <= ge ? diff[30:0] : trial[30:0];
                lo_reg  <= {lo_reg[14:0], ge};
                cnt_reg <= cnt_reg - 4'd1;
            end
            default:
            begin
                lo_reg <= lo_reg;
            end
        endcase
    end

    assign rsp.done     = (state_reg == wocs_pkg::CL_DONE);
    assign rsp.quotient = lo_reg;

endmodule

### design/waveform_oscillator_soft_clip_unit.sv
// tone generator top level: phase accumulator, waveform shaping and output register
// Usage
//   tick channel: each transfer asks for one pcm sample; restart = 1 clears the
//   phase and the sample counter before that sample is formed.
//   sample channel: one transfer per tick carrying pcm_sample (signed, within
//   +/-18750) and tone_end, high on the final sample of a tone.
//   cfg port: cfg_we with cfg_index 0 waveform_mode, 1 phase_step, 2 tone_length;
//   write only while the block is idle.
// Timing
//   a tick is taken from idle; its sample is then formed by the table lookup, the
//   two products, the steps of the restoring divider and a done step that loads
//   the output register. tick ready stays low from the tick until that load, so
//   the block takes no new tick while a sample is still being formed.
//   the result sits in an output register, so the next tick is taken while an
//   earlier sample still waits; a stalled receiver holds the block only when a
//   new result is finished and the register is still full.
// Reset
//   phase and counter clear, registers return to sine, step 25480000 and
//   length 13230, and no sample is pending.
`timescale 1ns / 1ps

module waveform_oscillator_soft_clip_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    wocs_tick_if.sink                       tick,
    wocs_sample_if.source                   sample,
    input  logic                            cfg_we,
    input  logic [wocs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wocs_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int STB = wocs_pkg::SINE_TABLE_BITS;
    localparam int CB  = wocs_pkg::COUNT_BITS;
    localparam int CW  = wocs_pkg::CMP_W;
    localparam int LW  = wocs_pkg::TONE_LEN_W;
    localparam int AW  = wocs_pkg::ADDR_W;

    wocs_pkg::wocs_state_t state_reg, state_next;

    logic [1:0]    mode_reg;
    logic [31:0]   step_reg;
    logic [LW-1:0] length_reg;
    logic [31:0]   phase_reg;
    logic [CB-1:0] count_reg;

    logic [15:0]   ph_hi_reg;
    logic          neg_reg;
    logic          last_reg;
    logic          out_valid_reg;
    logic [15:0]   pcm_reg;
    logic          end_reg;

    logic          accept;
    logic          load;
    logic [31:0]   phase_eff;
    logic [CB-1:0] count_eff;
    logic [LW-1:0] len_eff;
    logic          last;
    logic [15:0]   ph_hi_eff;
    logic [STB-1:0] frac;
    logic [AW-1:0] rom_addr;
    logic [15:0]   rom_data;
    logic [15:0]   mag;
    logic          neg;

    wocs_pkg::wocs_clip_req_t clip_req;
    wocs_pkg::wocs_clip_rsp_t clip_rsp;

    assign accept = tick.valid && tick.ready;
    assign tick.ready = (state_reg == wocs_pkg::ST_IDLE);

    // tone position after an optional restart
    assign phase_eff = tick.restart ? 32'd0 : phase_reg;
    assign count_eff = tick.restart ? '0 : count_reg;
    assign len_eff   = (length_reg == '0) ? LW'(1) : length_reg;
    assign last      = (CW'(count_eff) + CW'(1) >= CW'(len_eff)) || (count_eff == '1);

    // quarter-wave address, mirrored in odd quadrants
    assign ph_hi_eff = phase_eff[31:16];
    assign frac      = ph_hi_eff[13 -: STB];
    assign rom_addr  = ph_hi_eff[14] ? (AW'(wocs_pkg::QSTEPS) - AW'(frac)) : AW'(frac);

    wocs_sine_rom u_rom (
        .clk   (clk),
        .rd_en (accept),
        .addr  (rom_addr),
        .data  (rom_data)
    );

    // waveform magnitude and sign
    always_comb
    begin
        case (mode_reg)
            wocs_pkg::MODE_SAW:
            begin
                neg = !ph_hi_reg[15];
                mag = ph_hi_reg[15] ? {1'b0, ph_hi_reg[14:0]} : (wocs_pkg::ONE_Q15 - ph_hi_reg);
            end
            wocs_pkg::MODE_SQUARE:
            begin
                neg = ph_hi_reg[15];
                mag = wocs_pkg::ONE_Q15;
            end
            default:
            begin
                neg = ph_hi_reg[15];
                mag = rom_data;
            end
        endcase
    end

    assign clip_req.start     = (state_reg == wocs_pkg::ST_LOOKUP);
    assign clip_req.magnitude = mag;

    wocs_clip_unit u_clip (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (clip_req),
        .rsp   (clip_rsp)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= wocs_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        load       = 1'b0;
        unique case (state_reg)
            wocs_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = wocs_pkg::ST_LOOKUP;
            end
            wocs_pkg::ST_LOOKUP:
            begin
                state_next = wocs_pkg::ST_CLIP;
            end
            wocs_pkg::ST_CLIP:
            begin
                if (clip_rsp.done)
                begin
                    if (!out_valid_reg || sample.ready)
                    begin
                        load       = 1'b1;
                        state_next = wocs_pkg::ST_IDLE;
                    end
                    else
                        state_next = wocs_pkg::ST_HOLD;
                end
            end
            wocs_pkg::ST_HOLD:
            begin
                if (!out_valid_reg || sample.ready)
                begin
                    load       = 1'b1;
                    state_next = wocs_pkg::ST_IDLE;
                end
            end
            default: state_next = wocs_pkg::ST_IDLE;
        endcase
    end

    // configuration registers and tone position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= wocs_pkg::MODE_SINE;
            step_reg   <= wocs_pkg::PHASE_STEP_RESET;
            length_reg <= wocs_pkg::TONE_LENGTH_RESET;
            phase_reg  <= 32'd0;
            count_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    wocs_pkg::REG_WAVEFORM_MODE: mode_reg   <= cfg_data[1:0];
                    wocs_pkg::REG_PHASE_STEP:    step_reg   <= cfg_data[31:0];
                    wocs_pkg::REG_TONE_LENGTH:   length_reg <= cfg_data[LW-1:0];
                    default:                     mode_reg   <= mode_reg;
                endcase
            end
            if (accept)
            begin
                if (last)
                begin
                    phase_reg <= 32'd0;
                    count_reg <= '0;
                end
                else
                begin
                    phase_reg <= phase_eff + step_reg;
                    count_reg <= count_eff + CB'(1);
                end
            end
        end
    end

    // per-tick payload: phase and end flag at the transfer, sign in lookup, result at load
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ph_hi_reg <= ph_hi_eff;
            last_reg  <= last;
        end
        if (state_reg == wocs_pkg::ST_LOOKUP)
            neg_reg <= neg;
        if (load)
        begin
            pcm_reg <= neg_reg ? (16'd0 - clip_rsp.quotient) : clip_rsp.quotient;
            end_reg <= last_reg;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (sample.ready)
            out_valid_reg <= 1'b0;
    end

    assign sample.valid      = out_valid_reg;
    assign sample.pcm_sample = pcm_reg;
    assign sample.tone_end   = end_reg;

endmodule

### design/wocs_checker.sv
// port-level checks for the tone generator and their binding
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wocs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] pcm_sample
);

    // a stalled result stays offered and unchanged
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(pcm_sample))

    // the block is busy right after taking a tick and cannot answer at once
    `ASSERT_NEXT(a_busy_after_tick, clk, rst_n, in_valid && in_ready, !in_ready && !$rose(out_valid))

    // soft clip keeps samples inside the scaled range
    `ASSERT_IMPLIES(a_pcm_range, clk, rst_n, out_valid, pcm_sample <= 16'sd18750 && pcm_sample >= -16'sd18750)

endmodule

bind waveform_oscillator_soft_clip_unit wocs_checker u_wocs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (tick.valid),
    .in_ready   (tick.ready),
    .out_valid  (sample.valid),
    .out_ready  (sample.ready),
    .pcm_sample (sample.pcm_sample)
);

### sim/waveform_oscillator_soft_clip_unit_tb.sv
// self-checking testbench for the soft-clipped tone generator
`timescale 1ns / 1ps

module waveform_oscillator_soft_clip_unit_tb;

    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam int         GAP_MAX       = 13;
    localparam int         DRAIN_LIMIT   = 4000;
    localparam int         SETTLE_CYCLES = 30;
    localparam int         RANDOM_PHASES = 10;
    localparam int         PHASE_ITEMS   = 195;
    localparam int         REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [15:0] pcm_sample;
        logic        tone_end;
    } tone_sample_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [wocs_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [wocs_pkg::CFG_DATA_W-1:0]  cfg_data;

    wocs_tick_if   tick_ch ();
    wocs_sample_if sample_ch ();

    waveform_oscillator_soft_clip_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .sample    (sample_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // oscillator state and register copies kept by the testbench
    logic [31:0]                     osc_phase;
    logic [wocs_pkg::COUNT_BITS-1:0] osc_count;
    logic [1:0]                      osc_mode;
    logic [31:0]                     osc_step;
    logic [wocs_pkg::TONE_LEN_W-1:0] osc_length;
    logic [15:0]                     quarter_sine [0:wocs_pkg::QSTEPS];

    tone_sample_t pending_tone_samples [$];
    int           error_count = 0;
    bit           idle_on = 1'b1;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // quarter-wave entry from the integer taylor series, rounded to q1.15
    function automatic logic [15:0] sine_table_entry(int unsigned k);
        logic [63:0] angle;
        logic [63:0] angle_sq;
        logic [63:0] term;
        longint      sum;
        longint      rounded;
        int          n;
        angle    = (wocs_pkg::PI_HALF_Q30 * 64'(k) + 64'(wocs_pkg::QSTEPS / 2))
                   / 64'(wocs_pkg::QSTEPS);
        angle_sq = (angle * angle) >> 30;
        term     = angle;
        sum      = $signed(angle);
        for (n = 1; n <= 10; n++)
        begin
            term = ((term * angle_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = 0;
        rounded = (sum + 64'sd16384) >>> 15;
        if (rounded > 32768)
            rounded = 32768;
        return rounded[15:0];
    endfunction

    // waveform value in q1.15 for a phase
    function automatic int wave_point(logic [31:0] ph);
        logic [wocs_pkg::SINE_TABLE_BITS-1:0] idx;
        int                                   mag;
        case (osc_mode)
            wocs_pkg::MODE_SAW:    return int'(ph[31:16]) - 32768;
            wocs_pkg::MODE_SQUARE: return ph[31] ? -32768 : 32768;
            default:
            begin
                // sine, also for the unused code
                idx = ph[29 -: wocs_pkg::SINE_TABLE_BITS];
                mag = ph[30] ? int'(quarter_sine[wocs_pkg::QSTEPS - int'(idx)])
                             : int'(quarter_sine[idx]);
                return ph[31] ? -mag : mag;
            end
        endcase
    endfunction

    // s / (1 + 0.6|s|) scaled by 30000, truncated toward zero
    function automatic logic [15:0] soft_clip(int s);
        longint unsigned mag_in;
        longint unsigned num;
        longint unsigned den;
        longint unsigned mag_out;
        mag_in  = (s < 0) ? 64'(-s) : 64'(s);
        num     = mag_in * 64'(wocs_pkg::CLIP_SCALE) * 64'd32768;
        den     = (64'd1 << 30) + 64'(wocs_pkg::CLIP_K) * mag_in;
        mag_out = num / den;
        return (s < 0) ? 16'(-mag_out) : 16'(mag_out);
    endfunction

    // one tick of the oscillator: sample, tone end flag and state advance
    function automatic tone_sample_t next_tone_sample(logic restart_bit);
        tone_sample_t                  r;
        logic [wocs_pkg::TONE_LEN_W:0] len;
        logic                          last;
        if (restart_bit)
        begin
            osc_phase = '0;
            osc_count = '0;
        end
        r.pcm_sample = soft_clip(wave_point(osc_phase));
        len  = (osc_length == '0) ? (wocs_pkg::TONE_LEN_W + 1)'(1) : {1'b0, osc_length};
        last = (({1'b0, osc_count} + 1'b1) >= len) || (osc_count == '1);
        if (last)
        begin
            osc_phase = '0;
            osc_count = '0;
        end
        else
        begin
            osc_phase = osc_phase + osc_step;
            osc_count = osc_count + 1'b1;
        end
        r.tone_end = last;
        return r;
    endfunction

    // register write, block must be idle
    task automatic write_reg(logic [wocs_pkg::CFG_INDEX_W-1:0] idx,
                             logic [wocs_pkg::CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            wocs_pkg::REG_WAVEFORM_MODE: osc_mode   = value[1:0];
            wocs_pkg::REG_PHASE_STEP:    osc_step   = value;
            wocs_pkg::REG_TONE_LENGTH:   osc_length = value[wocs_pkg::TONE_LEN_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // one tick transfer, valid left high for a back-to-back follower
    task automatic send_tick(logic restart_bit);
        int gap;
        gap = idle_on ? $urandom_range(0, GAP_MAX) : 0;
        if (gap != 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_ch.valid   <= 1'b1;
        tick_ch.restart <= restart_bit;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        pending_tone_samples.push_back(next_tone_sample(restart_bit));
    endtask

    // stop sending and wait for every outstanding sample
    task automatic settle();
        int waited;
        tick_ch.valid <= 1'b0;
        waited = 0;
        while (pending_tone_samples.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_tone_samples.size() != 0)
        begin
            error_count += pending_tone_samples.size();
            $display("%0d samples never arrived", pending_tone_samples.size());
            pending_tone_samples.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register defaults straight after reset
    task automatic test_reset_defaults();
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
    endtask

    // every waveform code through all four quadrants and the phase top
    task automatic test_each_waveform();
        logic [1:0] mode_list [0:3];
        int         m;
        mode_list[0] = wocs_pkg::MODE_SINE;
        mode_list[1] = wocs_pkg::MODE_SAW;
        mode_list[2] = wocs_pkg::MODE_SQUARE;
        mode_list[3] = MODE_UNUSED;
        settle();
        write_reg(wocs_pkg::REG_TONE_LENGTH, 32'd4);
        write_reg(wocs_pkg::REG_PHASE_STEP, 32'h5555_5555);
        for (m = 0; m < 4; m++)
        begin
            settle();
            write_reg(wocs_pkg::REG_WAVEFORM_MODE, 32'(mode_list[m]));
            send_tick(1'b1);
            repeat (3) send_tick(1'b0);
        end
    endtask

    // zero length ends a tone on every sample
    task automatic test_zero_length();
        settle();
        write_reg(wocs_pkg::REG_TONE_LENGTH, 32'd0);
        send_tick(1'b0);
        send_tick(1'b0);
    endtask

    // full-scale step wraps the phase, restart in mid tone
    task automatic test_restart_and_wrap();
        settle();
        write_reg(wocs_pkg::REG_TONE_LENGTH, 32'd10);
        write_reg(wocs_pkg::REG_PHASE_STEP, 32'hFFFF_FFFF);
        write_reg(wocs_pkg::REG_WAVEFORM_MODE, 32'(wocs_pkg::MODE_SAW));
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
    endtask

    // random settings per phase, random ticks with occasional restarts
    task automatic test_random_phases();
        int          p;
        int          i;
        int          pick;
        int          pause_at;
        logic [31:0] step_val;
        logic [31:0] len_val;
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            // early phases walk through each setting choice in turn
            pick = (p < 5) ? p : $urandom_range(0, 4);
            case (pick)
                0:       step_val = 32'd0;
                1:       step_val = 32'hFFFF_FFFF;
                3:       step_val = $urandom_range(1, 32'h00FF_FFFF);
                default: step_val = $urandom;
            endcase
            pick = (p < 5) ? p : $urandom_range(0, 4);
            case (pick)
                0:       len_val = 32'd0;
                1:       len_val = 32'd1;
                2:       len_val = $urandom_range(2, 60);
                3:       len_val = 32'h000F_FFFF;
                default: len_val = $urandom_range(2, 32'h000F_FFFF);
            endcase
            write_reg(wocs_pkg::REG_WAVEFORM_MODE, (p < 4) ? 32'(p) : $urandom_range(0, 3));
            write_reg(wocs_pkg::REG_PHASE_STEP, step_val);
            write_reg(wocs_pkg::REG_TONE_LENGTH, len_val);
            idle_on  = ($urandom_range(0, 3) != 0);
            pause_at = $urandom_range(1, PHASE_ITEMS - 1);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == pause_at)
                    settle();
                send_tick($urandom_range(0, 19) == 0);
            end
        end
        idle_on = 1'b1;
    endtask

    // sample receiver with random stalls, compares against the oldest prediction
    initial
    begin : sample_checker
        tone_sample_t want;
        int           stall;
        sample_ch.ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, GAP_MAX) : 0;
            if (stall != 0)
            begin
                sample_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            sample_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!sample_ch.valid);
            if (pending_tone_samples.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected sample transfer: pcm %0d end %0b",
                             $signed(sample_ch.pcm_sample), sample_ch.tone_end);
            end
            else
            begin
                want = pending_tone_samples.pop_front();
                if (sample_ch.pcm_sample !== want.pcm_sample ||
                    sample_ch.tone_end !== want.tone_end)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("sample mismatch: pcm exp %0d got %0d, end exp %0b got %0b",
                                 $signed(want.pcm_sample), $signed(sample_ch.pcm_sample),
                                 want.tone_end, sample_ch.tone_end);
                end
            end
        end
    end

    // reset, directed tests, random phases, final verdict
    initial
    begin : stimulus
        int k;
        for (k = 0; k <= wocs_pkg::QSTEPS; k++)
            quarter_sine[k] = sine_table_entry(k);
        osc_phase       = '0;
        osc_count       = '0;
        osc_mode        = wocs_pkg::MODE_SINE;
        osc_step        = wocs_pkg::PHASE_STEP_RESET;
        osc_length      = wocs_pkg::TONE_LENGTH_RESET;
        rst_n           = 1'b0;
        tick_ch.valid   = 1'b0;
        tick_ch.restart = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = wocs_pkg::REG_WAVEFORM_MODE;
        cfg_data        = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_each_waveform();
        test_zero_length();
        test_restart_and_wrap();
        test_random_phases();
        settle();

        if (error_count == 0)
            $display("waveform_oscillator_soft_clip_unit_tb: clean");
        else
            $display("waveform_oscillator_soft_clip_unit_tb: errors");
        $finish;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("waveform_oscillator_soft_clip_unit_tb: errors");
        $finish;
    end

endmodule

### files.f
+incdir+design
design/wocs_pkg.sv
design/wocs_channels.sv
design/wocs_sine_rom.sv
design/wocs_clip_unit.sv
design/waveform_oscillator_soft_clip_unit.sv
design/wocs_checker.sv
sim/waveform_oscillator_soft_clip_unit_tb.sv
